// ===== rtl/core/stq_pkg.sv =====
// shared types and codes for the sorted timer queue
package stq_pkg;

   localparam int ID_W      = 4;
   localparam int TIME_W    = 32;
   localparam int SLOT_MAX  = 16;
   localparam int REQ_W     = 72;
   localparam int RSP_W     = 40;

   // request kinds
   localparam logic [1:0] KIND_SET     = 2'd0;
   localparam logic [1:0] KIND_RESTART = 2'd1;
   localparam logic [1:0] KIND_KILL    = 2'd2;
   localparam logic [1:0] KIND_POLL    = 2'd3;

   // operations broadcast to the cell row
   localparam logic [1:0] OP_NOP    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_INSERT = 2'd2;
   localparam logic [1:0] OP_POP    = 2'd3;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] expiry;
   } entry_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] expiry;
   } cmd_type;

   localparam entry_type ENTRY_NONE = '0;

endpackage

// ===== rtl/core/sorted_timer_queue.sv =====
// sorted timer queue: control, slot expiry store and the row of queue cells
//
//  channel | dir | signals                         | contents
//  req     | in  | req_tvalid/tready/tdata/tuser   | set, restart, kill or poll request
//  rsp     | out | rsp_tvalid/tready/tdata/tuser/  | expiry reports, final time to next
//          |     | rsp_tlast                       | expiry, acknowledges
//
// set and restart pass through request capture and offset sum, expiry sum, insertion.
// kill and out-of-range requests pass through capture and acknowledge; poll passes
// through capture, then examines and pops the head once a cycle unless output stalls.
// reset clears the cell valid flags, queue and held time.
// a full output register stalls the sequencer; a new request is taken as soon as
// the last response of the previous one sits in the output register.
module sorted_timer_queue #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // timer_id[3:0], timeout_value[35:4], tick_now[67:36], zero pad
   input  logic [stq_pkg::REQ_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // expired_id[3:0], next_timeout[35:4], zero pad
   output logic [stq_pkg::RSP_W-1:0] rsp_tdata,
   // is_expiry[0]
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXP  = 3'd1;
   localparam logic [2:0] S_INS  = 3'd2;
   localparam logic [2:0] S_ACK  = 3'd3;
   localparam logic [2:0] S_POLL = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [stq_pkg::ID_W-1:0]     id_ff, id_in;
   logic [stq_pkg::TIME_W-1:0]   t_ff, t_in;
   logic [stq_pkg::TIME_W-1:0]   exp_ff, exp_in;
   logic [stq_pkg::TIME_W-1:0]   held_ff, held_in;
   logic [stq_pkg::TIME_W-1:0]   slot_ff [stq_pkg::SLOT_MAX];

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_user_ff, rsp_user_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [stq_pkg::RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                         accept, rsp_free, id_ok, full, due;
   logic [stq_pkg::ID_W-1:0]     req_id;
   logic [stq_pkg::TIME_W-1:0]   req_timeout, req_tick, head_diff, next_time;
   stq_pkg::cmd_type             cmd;

   stq_pkg::entry_type           entry_w [NUM_TIMERS];
   logic [NUM_TIMERS:0]          chain_w;
   logic [NUM_TIMERS-1:0]        vld;

   assign req_id      = req_tdata[3:0];
   assign req_timeout = req_tdata[35:4];
   assign req_tick    = req_tdata[67:36];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign id_ok      = int'(req_id) < NUM_TIMERS;
   assign full       = vld[NUM_TIMERS-1];

   assign head_diff  = entry_w[0].expiry - held_ff;
   assign due        = entry_w[0].valid &&
                       ((head_diff == '0) || head_diff[stq_pkg::TIME_W-1]);
   assign next_time  = entry_w[0].valid ? head_diff : '1;

   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      t_in         = t_ff;
      exp_in       = exp_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      cmd.op       = stq_pkg::OP_NOP;
      cmd.id       = id_ff;
      cmd.expiry   = exp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               id_in  = req_id;
               cmd.id = req_id;
               t_in   = (req_tuser == stq_pkg::KIND_RESTART)
                        ? slot_ff[req_id] + req_timeout - held_ff
                        : req_timeout;
               if (req_tuser == stq_pkg::KIND_POLL) begin
                  held_in  = req_tick;
                  state_in = S_POLL;
               end else if (id_ok) begin
                  // any old entry of this slot leaves the queue first
                  cmd.op   = stq_pkg::OP_REMOVE;
                  state_in = (req_tuser == stq_pkg::KIND_KILL) ? S_ACK : S_EXP;
               end else begin
                  state_in = S_ACK;
               end
            end
         end
         S_EXP: begin
            exp_in   = held_ff + (t_ff[stq_pkg::TIME_W-1] ? '0 : t_ff);
            state_in = S_INS;
         end
         S_INS, S_ACK: begin
            if (rsp_free) begin
               if (state_ff == S_INS && !full) begin
                  cmd.op = stq_pkg::OP_INSERT;
               end
               rsp_valid_in = 1'b1;
               rsp_user_in  = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_data_in  = '0;
               state_in     = S_IDLE;
            end
         end
         S_POLL: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (due) begin
                  cmd.op      = stq_pkg::OP_POP;
                  rsp_user_in = 1'b1;
                  rsp_last_in = 1'b0;
                  rsp_data_in = {4'b0, {stq_pkg::TIME_W{1'b0}}, entry_w[0].id};
               end else begin
                  rsp_user_in = 1'b0;
                  rsp_last_in = 1'b1;
                  rsp_data_in = {4'b0, next_time, {stq_pkg::ID_W{1'b0}}};
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < stq_pkg::SLOT_MAX; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == S_EXP) begin
            slot_ff[id_ff] <= exp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      t_ff        <= t_in;
      exp_ff      <= exp_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // pop starts the shift at the head; remove and insert start it at their hit
   assign chain_w[0] = (cmd.op == stq_pkg::OP_POP);

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      stq_pkg::entry_type prev_e, next_e;
      if (i == 0) begin : g_head
         assign prev_e = stq_pkg::ENTRY_NONE;
      end else begin : g_body
         assign prev_e = entry_w[i-1];
      end
      if (i == NUM_TIMERS - 1) begin : g_tail
         assign next_e = stq_pkg::ENTRY_NONE;
      end else begin : g_inner
         assign next_e = entry_w[i+1];
      end

      stq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .chain_in   (chain_w[i]),
         .entry      (entry_w[i]),
         .chain_out  (chain_w[i+1])
      );

      assign vld[i] = entry_w[i].valid;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // occupied cells always form an unbroken run from the head
   a_packed_row: assert property (@(posedge clock) disable iff (reset)
      ((vld + 1'b1) & vld) == '0)
      else $error("queue cells not packed towards the head");

   // expiry reports only come out of a poll still in progress
   a_expiry_in_poll: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> (state_ff == S_POLL))
      else $error("expiry report outside poll");

   // every accepted request leaves the sequencer busy in the following cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("request accepted without work");

endmodule

// ===== rtl/core/stq_cell.sv =====
// one place of the sorted queue: holds an entry and shifts with its neighbours
module stq_cell (
   input  logic                clock,
   input  logic                reset,
   input  stq_pkg::cmd_type    cmd,
   input  stq_pkg::entry_type  prev_entry,
   input  stq_pkg::entry_type  next_entry,
   input  logic                chain_in,
   output stq_pkg::entry_type  entry,
   output logic                chain_out
);

   logic                          valid_ff, valid_in;
   logic [stq_pkg::ID_W-1:0]      id_ff, id_in;
   logic [stq_pkg::TIME_W-1:0]    expiry_ff, expiry_in;
   logic [stq_pkg::TIME_W-1:0]    diff;
   logic                          hit;

   assign diff = cmd.expiry - expiry_ff;

   always_comb begin
      unique case (cmd.op)
         stq_pkg::OP_REMOVE: hit = valid_ff && (id_ff == cmd.id);
         // new entry goes in front of the first later or empty place
         stq_pkg::OP_INSERT: hit = !valid_ff || diff[stq_pkg::TIME_W-1];
         default:            hit = 1'b0;
      endcase
   end

   assign chain_out = chain_in || hit;

   always_comb begin
      valid_in  = valid_ff;
      id_in     = id_ff;
      expiry_in = expiry_ff;
      case (cmd.op) inside
         stq_pkg::OP_REMOVE, stq_pkg::OP_POP: begin
            // close the gap left by the removed entry
            if (chain_in || hit) begin
               valid_in  = next_entry.valid;
               id_in     = next_entry.id;
               expiry_in = next_entry.expiry;
            end
         end
         stq_pkg::OP_INSERT: begin
            if (chain_in) begin
               valid_in  = prev_entry.valid;
               id_in     = prev_entry.id;
               expiry_in = prev_entry.expiry;
            end else if (hit) begin
               valid_in  = 1'b1;
               id_in     = cmd.id;
               expiry_in = cmd.expiry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      expiry_ff <= expiry_in;
   end

   assign entry.valid  = valid_ff;
   assign entry.id     = id_ff;
   assign entry.expiry = expiry_ff;

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the sorted timer queue
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS   = 16;
   localparam int TOTAL_REQS  = 370;
   localparam int CALM_TAIL   = 60;
   localparam int LONG_HOLD   = 400;
   localparam int IDLE_LIMIT  = 3000;
   localparam int DRAIN_WAIT  = 40;
   localparam int NUM_ROWS    = 23;
   localparam logic [31:0] NO_TIMER = 32'hffff_ffff;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  id;
      logic [31:0] timeout;
      logic [31:0] tick;
   } timer_request_type;

   typedef struct packed {
      logic        is_expiry;
      logic [3:0]  id;
      logic [31:0] next_timeout;
      logic        last;
   } timer_event_type;

   // typed rows carry their single final response; the rest go to the queue model
   typedef struct packed {
      timer_request_type req;
      logic              typed;
      logic [31:0]       typed_next;
   } directed_row_type;

   logic                        clock;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [stq_pkg::REQ_W-1:0]   req_tdata  = '0;
   logic [1:0]                  req_tuser  = stq_pkg::KIND_SET;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [stq_pkg::RSP_W-1:0]   rsp_tdata;
   logic                        rsp_tuser;
   logic                        rsp_tlast;

   sorted_timer_queue #(.NUM_TIMERS(NUM_SLOTS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // queue model state
   logic [3:0]  model_queue_id     [NUM_SLOTS];
   logic [31:0] model_queue_expiry [NUM_SLOTS];
   logic [31:0] model_slot_expiry  [NUM_SLOTS];
   logic [31:0] model_held;
   int          model_count;

   timer_event_type step_events[$];
   timer_event_type awaited_events[$];

   int errors       = 0;
   int reqs_sent    = 0;
   int rsps_checked = 0;
   int expiries     = 0;
   int deepest      = 0;
   int idle_cycles  = 0;
   bit calm         = 1'b0;
   bit long_hold_req = 1'b0;

   function automatic void drop_timer(input logic [3:0] id);
      int i;
      int hit;
      hit = -1;
      for (i = 0; i < model_count; i++)
         if (hit < 0 && model_queue_id[i] == id) hit = i;
      if (hit >= 0) begin
         for (i = hit; i + 1 < model_count; i++) begin
            model_queue_id[i]     = model_queue_id[i + 1];
            model_queue_expiry[i] = model_queue_expiry[i + 1];
         end
         model_count--;
      end
   endfunction

   function automatic void arm_timer(input logic [3:0] id, input logic [31:0] offset);
      logic [31:0] t;
      logic [31:0] due;
      logic [31:0] diff;
      int          pos;
      int          j;
      t = offset[31] ? 32'd0 : offset;
      due = model_held + t;
      model_slot_expiry[id] = due;
      drop_timer(id);
      if (model_count < NUM_SLOTS) begin
         // goes behind every entry that is not later than itself
         pos = model_count;
         for (j = model_count - 1; j >= 0; j--) begin
            diff = due - model_queue_expiry[j];
            if (diff[31]) pos = j;
         end
         for (j = model_count; j > pos; j--) begin
            model_queue_id[j]     = model_queue_id[j - 1];
            model_queue_expiry[j] = model_queue_expiry[j - 1];
         end
         model_queue_id[pos]     = id;
         model_queue_expiry[pos] = due;
         model_count++;
      end
   endfunction

   function automatic void step_timer_queue(input timer_request_type r);
      logic [31:0] next;
      logic [31:0] d;
      logic [3:0]  head;
      bit          waiting;
      int          drained;
      step_events.delete();
      if (r.kind == stq_pkg::KIND_POLL) begin
         model_held = r.tick;
         next = NO_TIMER;
         waiting = 1'b0;
         drained = 0;
         while (model_count > 0 && !waiting) begin
            d = model_queue_expiry[0] - model_held;
            if (d != 32'd0 && !d[31]) begin
               next = d;
               waiting = 1'b1;
            end else begin
               head = model_queue_id[0];
               drop_timer(head);
               step_events.push_back('{1'b1, head, 32'd0, 1'b0});
               drained++;
            end
         end
         if (drained > deepest) deepest = drained;
         step_events.push_back('{1'b0, 4'd0, next, 1'b1});
      end else begin
         case (r.kind)
            stq_pkg::KIND_SET:     arm_timer(r.id, r.timeout);
            stq_pkg::KIND_RESTART: arm_timer(r.id,
                                             model_slot_expiry[r.id] + r.timeout - model_held);
            default:               drop_timer(r.id);
         endcase
         step_events.push_back('{1'b0, 4'd0, 32'd0, 1'b1});
      end
   endfunction

   // offers one request, waits for it to be taken and records what it should cause
   task automatic offer_request(input timer_request_type r, input logic typed,
                                input logic [31:0] typed_next);
      int gap;
      bit took;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {4'd0, r.tick, r.timeout, r.id};
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      step_timer_queue(r);
      if (typed)
         awaited_events.push_back('{1'b0, 4'd0, typed_next, 1'b1});
      else
         foreach (step_events[k]) awaited_events.push_back(step_events[k]);
      reqs_sent++;
      if (reqs_sent >= TOTAL_REQS - CALM_TAIL) calm = 1'b1;
      if (reqs_sent == 150) long_hold_req = 1'b1;
   endtask

   function automatic logic [31:0] pick_timeout();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return 32'($urandom_range(0, 300));
      if (sel < 8) return 32'd0 - 32'($urandom_range(1, 200));
      return $urandom;
   endfunction

   function automatic timer_request_type random_request();
      timer_request_type r;
      int unsigned       sel;
      sel = $urandom_range(0, 19);
      r.id   = 4'($urandom_range(0, NUM_SLOTS - 1));
      r.tick = $urandom;
      r.timeout = pick_timeout();
      if (sel <= 6) begin
         r.kind = stq_pkg::KIND_SET;
      end else if (sel <= 9) begin
         r.kind = stq_pkg::KIND_RESTART;
         if ($urandom_range(0, 3) != 0) r.timeout = 32'($urandom_range(0, 300)) - 32'd150;
      end else if (sel <= 12) begin
         r.kind = stq_pkg::KIND_KILL;
      end else if (sel <= 18) begin
         r.kind = stq_pkg::KIND_POLL;
         sel = $urandom_range(0, 9);
         if (sel < 7) r.tick = model_held + 32'($urandom_range(0, 200));
         else if (sel < 9) r.tick = model_held - 32'($urandom_range(0, 50));
      end else begin
         // fully random fields
         r.kind = 2'($urandom_range(0, 3));
         r.timeout = $urandom;
      end
      return r;
   endfunction

   directed_row_type rows [NUM_ROWS];

   initial begin
      timer_request_type r;
      logic [3:0]        order [NUM_SLOTS];
      logic [3:0]        swap;
      int                i;
      int                j;
      bit                fill_due;

      for (i = 0; i < NUM_SLOTS; i++) begin
         model_queue_id[i]     = 4'd0;
         model_queue_expiry[i] = 32'd0;
         model_slot_expiry[i]  = 32'd0;
      end
      model_held  = 32'd0;
      model_count = 0;

      rows = '{
         '{'{stq_pkg::KIND_POLL,    4'd0,  32'd0,         32'd0},         1'b1, NO_TIMER},
         '{'{stq_pkg::KIND_SET,     4'd0,  32'd100,       32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_SET,     4'd3,  32'd100,       32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_SET,     4'd15, 32'h7fff_ffff, 32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_SET,     4'd1,  32'h8000_0000, 32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_SET,     4'd2,  32'hffff_ffff, 32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_RESTART, 4'd0,  32'd50,        32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_KILL,    4'd3,  32'd0,         32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_KILL,    4'd3,  32'd0,         32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_RESTART, 4'd4,  32'd10,        32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_SET,     4'd0,  32'd120,       32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_POLL,    4'd0,  32'd0,         32'd0},         1'b0, 32'd0},
         '{'{stq_pkg::KIND_POLL,    4'd0,  32'd0,         32'hffff_ffff}, 1'b0, 32'd0},
         '{'{stq_pkg::KIND_POLL,    4'd0,  32'd0,         32'd200},       1'b0, 32'd0},
         '{'{stq_pkg::KIND_RESTART, 4'd0,  32'h8000_0000, 32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_RESTART, 4'd6,  32'hffff_0000, 32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_SET,     4'd5,  32'h7fff_ffff, 32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_POLL,    4'd0,  32'd0,         32'h8000_0000}, 1'b0, 32'd0},
         '{'{stq_pkg::KIND_KILL,    4'd15, 32'd0,         32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_KILL,    4'd0,  32'd0,         32'd0},         1'b1, 32'd0},
         '{'{stq_pkg::KIND_POLL,    4'd0,  32'd0,         32'hffff_ffff}, 1'b0, 32'd0},
         '{'{stq_pkg::KIND_SET,     4'd7,  32'd0,         32'd0},         1'b1, 32'd0},
         // expiry equal to the tick counts as due
         '{'{stq_pkg::KIND_POLL,    4'd0,  32'd0,         32'hffff_ffff}, 1'b0, 32'd0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[k]) offer_request(rows[k].req, rows[k].typed, rows[k].typed_next);

      fill_due = 1'b1;
      while (reqs_sent < TOTAL_REQS) begin
         if (fill_due) begin
            // arm every slot in shuffled order, then drain them all in one poll
            for (i = 0; i < NUM_SLOTS; i++) order[i] = 4'(i);
            for (i = NUM_SLOTS - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               swap = order[i];
               order[i] = order[j];
               order[j] = swap;
            end
            for (i = 0; i < NUM_SLOTS; i++) begin
               r = '{stq_pkg::KIND_SET, order[i], 32'($urandom_range(0, 60)), $urandom};
               offer_request(r, 1'b0, 32'd0);
            end
            r = '{stq_pkg::KIND_POLL, 4'($urandom_range(0, 15)), $urandom,
                  model_held + 32'd100};
            offer_request(r, 1'b0, 32'd0);
         end else begin
            offer_request(random_request(), 1'b0, 32'd0);
         end
         fill_due = (!calm && $urandom_range(0, 24) == 0);
      end
      req_tvalid <= 1'b0;

      while (awaited_events.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d requests sent, %0d responses checked, %0d timer expiries reported",
               reqs_sent, rsps_checked, expiries);
      $display("largest single poll drain: %0d timers", deepest);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side: random stall bursts plus one long hold to back the queue up
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // inputs only change at the rising edge, so the falling edge sees settled values
   always @(negedge clock) begin
      timer_event_type seen;
      timer_event_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("%0t ns: no handshake for %0d cycles, %0d responses outstanding",
                        $time, IDLE_LIMIT, awaited_events.size());
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = '{rsp_tuser, rsp_tdata[3:0], rsp_tdata[35:4], rsp_tlast};
            if (awaited_events.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, got %h", $time, seen);
               errors++;
            end else begin
               want = awaited_events.pop_front();
               rsps_checked++;
               if (want.is_expiry) expiries++;
               if (seen.is_expiry !== want.is_expiry) begin
                  $display("%0t ns: is_expiry expected %0d got %0d",
                           $time, want.is_expiry, seen.is_expiry);
                  errors++;
               end
               if (seen.id !== want.id) begin
                  $display("%0t ns: expired_id expected %0d got %0d", $time, want.id, seen.id);
                  errors++;
               end
               if (seen.next_timeout !== want.next_timeout) begin
                  $display("%0t ns: next_timeout expected %h got %h",
                           $time, want.next_timeout, seen.next_timeout);
                  errors++;
               end
               if (seen.last !== want.last) begin
                  $display("%0t ns: last expected %0d got %0d", $time, want.last, seen.last);
                  errors++;
               end
            end
         end
      end
   end

endmodule

// ===== files.f =====
rtl/core/stq_pkg.sv
rtl/core/stq_cell.sv
rtl/core/sorted_timer_queue.sv
dv/testbench.sv
